>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the pixel converter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RY_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define RY_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define RY_ASSERT(label, clk, rst, prop)
`define RY_NEVER(label, clk, rst, cond)

`endif

`endif

>>> sv/rgb_yuv_pkg.sv
// Shared types, constants and helpers for the RGB to YUV 4:2:0 converter.
// No dependencies.
`default_nettype none

package rgb_yuv_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [CSR_W-1:0] RESET_HEIGHT = 13'd480;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   localparam int PIX_W  = 8;
   localparam int LIDX_W = 24;
   localparam int CIDX_W = 22;

   // Q16 coefficients, magnitudes only; signs are applied in the adder.
   localparam int COEF_W = 17;
   localparam int PROD_W = PIX_W + COEF_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic [COEF_W-1:0] COEF_YR = 17'd19595;
   localparam logic [COEF_W-1:0] COEF_YG = 17'd38470;
   localparam logic [COEF_W-1:0] COEF_YB = 17'd7471;
   localparam logic [COEF_W-1:0] COEF_UR = 17'd9634;
   localparam logic [COEF_W-1:0] COEF_UG = 17'd18940;
   localparam logic [COEF_W-1:0] COEF_UB = 17'd28574;
   localparam logic [COEF_W-1:0] COEF_VR = 17'd40305;
   localparam logic [COEF_W-1:0] COEF_VG = 17'd33751;
   localparam logic [COEF_W-1:0] COEF_VB = 17'd6554;
   localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 27'sd8388608;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0]  red;
      logic [PIX_W-1:0]  green;
      logic [PIX_W-1:0]  blue;
      logic [LIDX_W-1:0] luma_index;
      logic              chroma_valid;
      logic [CIDX_W-1:0] chroma_index;
      logic              frame_last;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0]  luma;
      logic [LIDX_W-1:0] luma_index;
      logic              chroma_valid;
      logic [PIX_W-1:0]  chroma_u;
      logic [PIX_W-1:0]  chroma_v;
      logic [CIDX_W-1:0] chroma_index;
      logic              frame_last;
   } result_type;

   // Floor of sum / 65536, clamped to 0..255.
   function automatic logic [PIX_W-1:0] floor_clamp(input logic signed [SUM_W-1:0] sum);
      logic [PIX_W-1:0] q;
      if (sum[SUM_W-1]) begin
         q = '0;
      end else if (|sum[SUM_W-2:24]) begin
         q = 8'hFF;
      end else begin
         q = sum[23:16];
      end
      return q;
   endfunction

endpackage

`default_nettype wire

>>> sv/rgb_yuv_fifo.sv
// Small synchronous FIFO with combinational read of the head entry.
// No dependencies; used for the front/back queue and the result queue.
`default_nettype none

module rgb_yuv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           din,
   output logic                            full,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                dout,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW:0]      wr_ff, wr_in;
   logic [AW:0]      rd_ff, rd_in;
   logic [AW:0]      level;
   logic             do_push, do_pop;

   assign level   = wr_ff - rd_ff;
   assign full    = (level == (AW+1)'(DEPTH));
   assign empty   = (level == '0);
   assign count   = ($clog2(DEPTH+1))'(level);
   assign dout    = mem[rd_ff[AW-1:0]];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff[AW-1:0]] <= din;
      end
   end

endmodule

`default_nettype wire

>>> sv/rgb_yuv_front.sv
// Front end: frame registers, raster counters and pixel classification.
// Depends on rgb_yuv_pkg.
`default_nettype none

module rgb_yuv_front #(
   parameter int MAX_WIDTH  = rgb_yuv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rgb_yuv_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [rgb_yuv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rgb_yuv_pkg::CSR_W-1:0]       csr_data,
   input  wire logic                                req_push,
   input  wire logic [rgb_yuv_pkg::PIX_W-1:0]       req_red,
   input  wire logic [rgb_yuv_pkg::PIX_W-1:0]       req_green,
   input  wire logic [rgb_yuv_pkg::PIX_W-1:0]       req_blue,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output rgb_yuv_pkg::pixel_type                   q_item
);

   localparam int CSR_W = rgb_yuv_pkg::CSR_W;
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int WEW   = (CW > CSR_W) ? CW : CSR_W;
   localparam int HEW   = (RW > CSR_W) ? RW : CSR_W;

   logic [CSR_W-1:0]                  width_ff, width_in;
   logic [CSR_W-1:0]                  height_ff, height_in;
   logic [CW-1:0]                     col_ff, col_in;
   logic [RW-1:0]                     row_ff, row_in;
   logic [rgb_yuv_pkg::LIDX_W-1:0]    lpos_ff, lpos_in;
   logic [rgb_yuv_pkg::CIDX_W-1:0]    cpos_ff, cpos_in;

   logic [WEW-1:0] w_raw, w_eff;
   logic [HEW-1:0] h_raw, h_eff;
   logic           cv, row_end, last, accept;

   // Effective sizes: even, at least 2, at most the built-in limit.
   always_comb begin
      w_raw = WEW'({width_ff[CSR_W-1:1], 1'b0});
      if (w_raw < WEW'(2)) begin
         w_eff = WEW'(2);
      end else if (w_raw > WEW'(MAX_WIDTH)) begin
         w_eff = WEW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      h_raw = HEW'({height_ff[CSR_W-1:1], 1'b0});
      if (h_raw < HEW'(2)) begin
         h_eff = HEW'(2);
      end else if (h_raw > HEW'(MAX_HEIGHT)) begin
         h_eff = HEW'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
   end

   assign cv      = !col_ff[0] && !row_ff[0];
   assign row_end = (WEW'(col_ff) + WEW'(1)) >= w_eff;
   assign last    = row_end && ((HEW'(row_ff) + HEW'(1)) >= h_eff);
   assign accept  = req_push && !q_full;
   assign q_push  = accept;

   always_comb begin
      q_item.red          = req_red;
      q_item.green        = req_green;
      q_item.blue         = req_blue;
      q_item.luma_index   = lpos_ff;
      q_item.chroma_valid = cv;
      q_item.chroma_index = cv ? cpos_ff : '0;
      q_item.frame_last   = last;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      lpos_in   = lpos_ff;
      cpos_in   = cpos_ff;
      if (csr_write) begin
         // Any register write restarts the frame.
         case (rgb_yuv_pkg::csr_index_type'(csr_index))
            rgb_yuv_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_data;
               col_in   = '0;
               row_in   = '0;
               lpos_in  = '0;
               cpos_in  = '0;
            end
            rgb_yuv_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_data;
               col_in    = '0;
               row_in    = '0;
               lpos_in   = '0;
               cpos_in   = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (last) begin
            col_in  = '0;
            row_in  = '0;
            lpos_in = '0;
            cpos_in = '0;
         end else begin
            lpos_in = lpos_ff + 1'b1;
            if (cv) begin
               cpos_in = cpos_ff + 1'b1;
            end
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rgb_yuv_pkg::RESET_WIDTH;
         height_ff <= rgb_yuv_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         lpos_ff   <= '0;
         cpos_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         lpos_ff   <= lpos_in;
         cpos_ff   <= cpos_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/rgb_yuv_back.sv
// Back end: two-stage color matrix (products, then sums with floor/clamp).
// Depends on rgb_yuv_pkg. Issues only when the result queue has a free slot.
`default_nettype none

module rgb_yuv_back #(
   parameter int OUT_DEPTH = rgb_yuv_pkg::OUT_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                item_valid,
   input  wire rgb_yuv_pkg::pixel_type              item,
   output logic                                     item_take,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]      out_level,
   output logic                                     res_valid,
   output rgb_yuv_pkg::result_type                  res
);

   localparam int CW     = $clog2(OUT_DEPTH + 1);
   localparam int PROD_W = rgb_yuv_pkg::PROD_W;
   localparam int SUM_W  = rgb_yuv_pkg::SUM_W;

   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   rgb_yuv_pkg::pixel_type meta_ff;
   rgb_yuv_pkg::result_type res_ff, res_in;
   logic [PROD_W-1:0] yr_ff, yg_ff, yb_ff;
   logic [PROD_W-1:0] ur_ff, ug_ff, ub_ff;
   logic [PROD_W-1:0] vr_ff, vg_ff, vb_ff;
   logic [CW:0]       occupancy;
   logic signed [SUM_W-1:0] ys, us, vs;

   // Credit: queued results plus both stages must leave room for one more.
   assign occupancy = {1'b0, out_level} + (CW+1)'(v1_ff) + (CW+1)'(v2_ff);
   assign item_take = item_valid && (occupancy < (CW+1)'(OUT_DEPTH));
   assign v1_in     = item_take;
   assign v2_in     = v1_ff;

   always_comb begin
      ys = $signed({2'b00, yr_ff}) + $signed({2'b00, yg_ff}) + $signed({2'b00, yb_ff});
      us = rgb_yuv_pkg::CHROMA_OFFSET + $signed({2'b00, ub_ff})
           - $signed({2'b00, ur_ff}) - $signed({2'b00, ug_ff});
      vs = rgb_yuv_pkg::CHROMA_OFFSET + $signed({2'b00, vr_ff})
           - $signed({2'b00, vg_ff}) - $signed({2'b00, vb_ff});
      res_in.luma         = rgb_yuv_pkg::floor_clamp(ys);
      res_in.luma_index   = meta_ff.luma_index;
      res_in.chroma_valid = meta_ff.chroma_valid;
      res_in.chroma_u     = meta_ff.chroma_valid ? rgb_yuv_pkg::floor_clamp(us) : '0;
      res_in.chroma_v     = meta_ff.chroma_valid ? rgb_yuv_pkg::floor_clamp(vs) : '0;
      res_in.chroma_index = meta_ff.chroma_index;
      res_in.frame_last   = meta_ff.frame_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         meta_ff <= item;
         yr_ff   <= PROD_W'(item.red)   * PROD_W'(rgb_yuv_pkg::COEF_YR);
         yg_ff   <= PROD_W'(item.green) * PROD_W'(rgb_yuv_pkg::COEF_YG);
         yb_ff   <= PROD_W'(item.blue)  * PROD_W'(rgb_yuv_pkg::COEF_YB);
         ur_ff   <= PROD_W'(item.red)   * PROD_W'(rgb_yuv_pkg::COEF_UR);
         ug_ff   <= PROD_W'(item.green) * PROD_W'(rgb_yuv_pkg::COEF_UG);
         ub_ff   <= PROD_W'(item.blue)  * PROD_W'(rgb_yuv_pkg::COEF_UB);
         vr_ff   <= PROD_W'(item.red)   * PROD_W'(rgb_yuv_pkg::COEF_VR);
         vg_ff   <= PROD_W'(item.green) * PROD_W'(rgb_yuv_pkg::COEF_VG);
         vb_ff   <= PROD_W'(item.blue)  * PROD_W'(rgb_yuv_pkg::COEF_VB);
      end
      if (v1_ff) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = v2_ff;
   assign res       = res_ff;

endmodule

`default_nettype wire

>>> sv/rgb_to_yuv420_point_sampled.sv
// Top level of the RGB to YUV 4:2:0 converter.
// Depends on rgb_yuv_pkg, rgb_yuv_front, rgb_yuv_fifo, rgb_yuv_back, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Converts a raster stream of RGB pixels to BT.601-style YUV 4:2:0. Every
// pixel gives luma and its luma-plane index; pixels on even rows and even
// columns also give U and V (point sampled, top-left of each 2x2 block) and
// their chroma-plane index, otherwise those fields read zero. frame_last marks
// the final pixel of the frame. One pixel is accepted every clock cycle while
// the result side keeps popping; a result reaches the result ports through the
// two-entry queue behind the counters, a product stage, a sum and clamp stage,
// then the four-entry result queue. Writing either size register restarts the
// frame; write only while the block is drained.
module rgb_to_yuv420_point_sampled #(
   parameter int MAX_WIDTH  = rgb_yuv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rgb_yuv_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [rgb_yuv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rgb_yuv_pkg::CSR_W-1:0]       csr_data,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [rgb_yuv_pkg::PIX_W-1:0]       req_red,
   input  wire logic [rgb_yuv_pkg::PIX_W-1:0]       req_green,
   input  wire logic [rgb_yuv_pkg::PIX_W-1:0]       req_blue,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [rgb_yuv_pkg::PIX_W-1:0]            rsp_luma,
   output logic [rgb_yuv_pkg::LIDX_W-1:0]           rsp_luma_index,
   output logic                                     rsp_chroma_valid,
   output logic [rgb_yuv_pkg::PIX_W-1:0]            rsp_chroma_u,
   output logic [rgb_yuv_pkg::PIX_W-1:0]            rsp_chroma_v,
   output logic [rgb_yuv_pkg::CIDX_W-1:0]           rsp_chroma_index,
   output logic                                     rsp_frame_last
);

   localparam int MID_DEPTH = rgb_yuv_pkg::MID_DEPTH;
   localparam int OUT_DEPTH = rgb_yuv_pkg::OUT_DEPTH;
   localparam int MID_LW    = $clog2(MID_DEPTH + 1);
   localparam int PW        = $bits(rgb_yuv_pkg::pixel_type);
   localparam int RSW       = $bits(rgb_yuv_pkg::result_type);

   logic                                mid_full, mid_empty, front_push, back_take;
   rgb_yuv_pkg::pixel_type              front_item, mid_item;
   logic [PW-1:0]                       mid_dout;
   logic [MID_LW-1:0]                   mid_level;
   logic                                back_valid, out_full;
   rgb_yuv_pkg::result_type             back_res, out_res;
   logic [RSW-1:0]                      out_dout;
   logic [$clog2(OUT_DEPTH+1)-1:0]      out_level;
   logic                                chroma_nz;

   assign req_full = mid_full;

   rgb_yuv_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_full    (mid_full),
      .q_push    (front_push),
      .q_item    (front_item)
   );

   rgb_yuv_fifo #(
      .WIDTH (PW),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .din   (front_item),
      .full  (mid_full),
      .pop   (back_take),
      .dout  (mid_dout),
      .empty (mid_empty),
      .count (mid_level)
   );

   assign mid_item = rgb_yuv_pkg::pixel_type'(mid_dout);

   rgb_yuv_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item       (mid_item),
      .item_take  (back_take),
      .out_level  (out_level),
      .res_valid  (back_valid),
      .res        (back_res)
   );

   rgb_yuv_fifo #(
      .WIDTH (RSW),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (back_valid),
      .din   (back_res),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (out_dout),
      .empty (rsp_empty),
      .count (out_level)
   );

   assign out_res          = rgb_yuv_pkg::result_type'(out_dout);
   assign rsp_luma         = out_res.luma;
   assign rsp_luma_index   = out_res.luma_index;
   assign rsp_chroma_valid = out_res.chroma_valid;
   assign rsp_chroma_u     = out_res.chroma_u;
   assign rsp_chroma_v     = out_res.chroma_v;
   assign rsp_chroma_index = out_res.chroma_index;
   assign rsp_frame_last   = out_res.frame_last;

   assign chroma_nz = |{rsp_chroma_u, rsp_chroma_v, rsp_chroma_index};

   // Credit scheme must keep the result queue from ever overflowing.
   `RY_NEVER(a_out_no_overflow, clock, reset, back_valid && out_full)
   // Back end only takes from a non-empty queue.
   `RY_NEVER(a_take_nonempty, clock, reset, back_take && mid_empty)
   // Front/back queue never holds more than its depth.
   `RY_NEVER(a_mid_bound, clock, reset, mid_level > MID_LW'(MID_DEPTH))
   // Non-chroma results carry zeroed chroma fields.
   `RY_ASSERT(a_chroma_zero, clock, reset, !rsp_empty && !rsp_chroma_valid |-> !chroma_nz)

endmodule

`default_nettype wire

>>> tb/rgb_to_yuv420_checker.sv
// Scoreboard for the RGB to YUV 4:2:0 converter: tracks size writes and accepted
// pixels, predicts every result and compares each popped result field by field.
// Depends on rgb_yuv_pkg.
module rgb_to_yuv420_checker
   import rgb_yuv_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data,
   input  wire logic                 req_push,
   input  wire logic                 req_full,
   input  wire logic [PIX_W-1:0]     req_red,
   input  wire logic [PIX_W-1:0]     req_green,
   input  wire logic [PIX_W-1:0]     req_blue,
   input  wire logic                 rsp_empty,
   input  wire logic                 rsp_pop,
   input  wire logic [PIX_W-1:0]     rsp_luma,
   input  wire logic [LIDX_W-1:0]    rsp_luma_index,
   input  wire logic                 rsp_chroma_valid,
   input  wire logic [PIX_W-1:0]     rsp_chroma_u,
   input  wire logic [PIX_W-1:0]     rsp_chroma_v,
   input  wire logic [CIDX_W-1:0]    rsp_chroma_index,
   input  wire logic                 rsp_frame_last,
   output int                        mismatch_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHROMA_BIAS = 128 << 16;

   logic [CSR_W-1:0]  width_reg;
   logic [CSR_W-1:0]  height_reg;
   int unsigned       column_count;
   int unsigned       row_count;
   logic [LIDX_W-1:0] luma_pos;
   logic [CIDX_W-1:0] chroma_pos;
   int                fail_total;
   result_type        expected_q[$];

   // Low bit dropped, then held to 2..limit.
   function automatic int unsigned even_size(logic [CSR_W-1:0] size_reg, int unsigned limit);
      int unsigned s;
      s = 32'({size_reg[CSR_W-1:1], 1'b0});
      if (s < 2) s = 2;
      if (s > limit) s = limit;
      return s;
   endfunction

   // Q16 sum floored toward minus infinity, then clamped to a byte.
   function automatic logic [PIX_W-1:0] floor_byte(int sum);
      int q;
      q = sum >>> 16;
      if (q < 0) q = 0;
      else if (q > 255) q = 255;
      return q[PIX_W-1:0];
   endfunction

   function automatic void restart_frame();
      column_count = 0;
      row_count    = 0;
      luma_pos     = '0;
      chroma_pos   = '0;
   endfunction

   // Converts one pixel and advances the raster position.
   function automatic result_type convert_pixel(logic [PIX_W-1:0] r8, g8, b8);
      result_type  res;
      int          r, g, b;
      int unsigned w, h;
      logic        chroma_site, row_end;
      r = int'(r8);
      g = int'(g8);
      b = int'(b8);
      w = even_size(width_reg, MAX_WIDTH);
      h = even_size(height_reg, MAX_HEIGHT);
      chroma_site = !column_count[0] && !row_count[0];
      row_end = (column_count + 1) >= w;
      res.luma         = floor_byte(19595 * r + 38470 * g + 7471 * b);
      res.luma_index   = luma_pos;
      res.chroma_valid = chroma_site;
      res.chroma_u     = chroma_site ?
                         floor_byte(-9634 * r - 18940 * g + 28574 * b + CHROMA_BIAS) : '0;
      res.chroma_v     = chroma_site ?
                         floor_byte(40305 * r - 33751 * g - 6554 * b + CHROMA_BIAS) : '0;
      res.chroma_index = chroma_site ? chroma_pos : '0;
      res.frame_last   = row_end && ((row_count + 1) >= h);
      if (res.frame_last) begin
         restart_frame();
      end else begin
         luma_pos = luma_pos + 1'b1;
         if (chroma_site) chroma_pos = chroma_pos + 1'b1;
         if (row_end) begin
            column_count = 0;
            row_count    = row_count + 1;
         end else begin
            column_count = column_count + 1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : track
      result_type got, want;
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         restart_frame();
         expected_q.delete();
         fail_total = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
            restart_frame();
         end
         // Result side first: a result never leaves in the cycle its pixel enters.
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_luma, rsp_luma_index, rsp_chroma_valid, rsp_chroma_u,
                    rsp_chroma_v, rsp_chroma_index, rsp_frame_last};
            if (expected_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: result transfer with nothing expected: %p", $realtime, got);
            end else begin
               want = expected_q.pop_front();
               if (got.luma !== want.luma || got.luma_index !== want.luma_index ||
                   got.chroma_valid !== want.chroma_valid ||
                   got.chroma_u !== want.chroma_u || got.chroma_v !== want.chroma_v ||
                   got.chroma_index !== want.chroma_index ||
                   got.frame_last !== want.frame_last) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %p", want);
                     $display("   actual   %p", got);
                  end
               end
            end
         end
         if (req_push && !req_full)
            expected_q = {expected_q, convert_pixel(req_red, req_green, req_blue)};
      end
      mismatch_count <= fail_total;
      pending_count  <= expected_q.size();
   end

endmodule

>>> tb/rgb_to_yuv420_point_sampled_tb.sv
// Testbench top for the RGB to YUV 4:2:0 converter: clock, reset, size writes,
// pixel stimulus and result popping, verdict. Depends on rgb_yuv_pkg,
// rgb_to_yuv420_point_sampled and rgb_to_yuv420_checker.
module rgb_to_yuv420_point_sampled_tb;
   import rgb_yuv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CSR_W-1:0]     csr_data = '0;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [PIX_W-1:0]     req_red = '0;
   logic [PIX_W-1:0]     req_green = '0;
   logic [PIX_W-1:0]     req_blue = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [PIX_W-1:0]     rsp_luma;
   logic [LIDX_W-1:0]    rsp_luma_index;
   logic                 rsp_chroma_valid;
   logic [PIX_W-1:0]     rsp_chroma_u;
   logic [PIX_W-1:0]     rsp_chroma_v;
   logic [CIDX_W-1:0]    rsp_chroma_index;
   logic                 rsp_frame_last;
   int                   mismatch_count;
   int                   pending_count;

   int sender_idle_pct = 17;
   int receiver_idle_pct = 71;
   int pixels_sent = 0;

   rgb_to_yuv420_point_sampled u_top (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_push, .req_full, .req_red, .req_green, .req_blue,
      .rsp_empty, .rsp_pop, .rsp_luma, .rsp_luma_index, .rsp_chroma_valid,
      .rsp_chroma_u, .rsp_chroma_v, .rsp_chroma_index, .rsp_frame_last
   );

   rgb_to_yuv420_checker u_checker (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_push, .req_full, .req_red, .req_green, .req_blue,
      .rsp_empty, .rsp_pop, .rsp_luma, .rsp_luma_index, .rsp_chroma_valid,
      .rsp_chroma_u, .rsp_chroma_v, .rsp_chroma_index, .rsp_frame_last,
      .mismatch_count, .pending_count
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Presents one pixel after a random gap and holds it until the transfer.
   task automatic send_pixel(logic [PIX_W-1:0] r, g, b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pixels_sent++;
      if (pixels_sent == 600) begin
         sender_idle_pct   <= 71;
         receiver_idle_pct <= 17;
      end else if (pixels_sent == 1200) begin
         sender_idle_pct   <= 0;
         receiver_idle_pct <= 0;
      end
   endtask

   // Component biased toward the two extremes.
   function automatic logic [PIX_W-1:0] pick_component();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_size(csr_index_type idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_W-1:0];
      @(posedge clock);
   endtask

   // Stops pushing and waits until every expected result has been popped.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      // Per phase: -1 keeps the register, -2 picks a small random size.
      int width_plan[9]  = '{-1, 3, 0, 8191, 7, 4097, -2, -2, 2};
      int height_plan[9] = '{-1, 1, 5, 0, 8191, 6, -2, -2, -1};
      int pixel_plan[9]  = '{150, 200, 200, 200, 200, 150, 250, 250, 150};
      // Black, white, primaries, secondaries (clamp both ends of V) and mid gray.
      logic [PIX_W-1:0] corner_red[9]   = '{0, 255, 255, 0, 0, 0, 255, 255, 128};
      logic [PIX_W-1:0] corner_green[9] = '{0, 255, 0, 255, 0, 255, 255, 0, 128};
      logic [PIX_W-1:0] corner_blue[9]  = '{0, 255, 0, 0, 255, 255, 0, 255, 128};
      int w, h;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 9; phase++) begin
         w = (width_plan[phase] == -2) ? $urandom_range(0, 24) : width_plan[phase];
         h = (height_plan[phase] == -2) ? $urandom_range(0, 24) : height_plan[phase];
         if (w >= 0) write_size(CSR_FRAME_WIDTH, w);
         if (h >= 0) write_size(CSR_FRAME_HEIGHT, h);
         if (w >= 0 || h >= 0) begin
            csr_write <= 1'b0;
            @(posedge clock);
         end
         // Directed colors at the default frame and again at the smallest one.
         if (phase < 2)
            for (int i = 0; i < 9; i++)
               send_pixel(corner_red[i], corner_green[i], corner_blue[i]);
         for (int i = 0; i < pixel_plan[phase]; i++)
            send_pixel(pick_component(), pick_component(), pick_component());
         drain();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/rgb_yuv_pkg.sv
sv/rgb_yuv_fifo.sv
sv/rgb_yuv_front.sv
sv/rgb_yuv_back.sv
sv/rgb_to_yuv420_point_sampled.sv
tb/rgb_to_yuv420_checker.sv
tb/rgb_to_yuv420_point_sampled_tb.sv
